// File: hw/rtl/arp_responder_with_lru_cache_macros.svh
// Assertion macros used by the ARP responder cache engine (arpc_back).
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef ARP_RESPONDER_WITH_LRU_CACHE_MACROS_SVH
`define ARP_RESPONDER_WITH_LRU_CACHE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ARPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ARPC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/arpc_pkg.sv
// Types and constants of the ARP responder.
// Used by the front classifier, the command queue, the cache engine and the top level.
package arpc_pkg;

	localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
	localparam logic [10:0] MIN_FRAME    = 11'd14;
	localparam logic [15:0] ARP_OP_REQ   = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY = 16'd2;
	localparam logic [1:0]  OUT_OP_REQ   = 2'd1;
	localparam logic [1:0]  OUT_OP_REPLY = 2'd2;
	localparam logic [47:0] BCAST_MAC    = 48'hffff_ffff_ffff;

	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [2:0] CFG_NUM_IF   = 3'd0;
	localparam logic [2:0] CFG_PORT0_MAC = 3'd1;
	localparam logic [2:0] CFG_PORT0_IP  = 3'd2;
	localparam logic [2:0] CFG_PORT1_MAC = 3'd3;
	localparam logic [2:0] CFG_PORT1_IP  = 3'd4;

	typedef enum logic [3:0] {
		STAT_CACHED    = 4'd0,
		STAT_REPLY     = 4'd1,
		STAT_REQUEST   = 4'd2,
		STAT_HIT       = 4'd3,
		STAT_IGNORED   = 4'd4,
		STAT_NOTME     = 4'd5,
		STAT_MALFORMED = 4'd6,
		STAT_BADTYPE   = 4'd7,
		STAT_BADPORT   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_SIMPLE,
		CMD_REQREPLY,
		CMD_UPDATE,
		CMD_LOOKUP
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]  num_if;
		logic [47:0] mac0;
		logic [31:0] ip0;
		logic [47:0] mac1;
		logic [31:0] ip1;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t   kind;
		status_t     status;
		logic [1:0]  nrep;
		logic        port;
		logic [47:0] smac;
		logic [31:0] sip;
		logic [31:0] tip;
	} cmd_t;

	// Input word, last field in the lowest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] target_ip;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [15:0] arp_op;
		logic [15:0] ethertype;
		logic [10:0] frame_bytes;
		logic        port;
	} in_word_t;

	// Result word, last field in the lowest bits.
	typedef struct packed {
		logic        pad;
		logic [47:0] found_mac;
		logic [31:0] out_target_ip;
		logic [47:0] out_target_mac;
		logic [31:0] out_sender_ip;
		logic [47:0] out_sender_mac;
		logic [1:0]  out_op;
		logic [47:0] eth_src;
		logic [47:0] eth_dst;
		logic        out_port;
		status_t     status;
	} out_word_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic        port;
		logic [31:0] stamp;
	} entry_t;

endpackage

// File: hw/rtl/arp_responder_with_lru_cache.sv
// ARP responder with an LRU IP-to-MAC cache.
// Uses arpc_pkg, arpc_front, arpc_cmd_fifo and arpc_back.
//
// Input stream s_*: one word per received ARP frame, lookup query or
// one-second tick; tuser carries the kind. Output stream m_*: result words,
// tlast on the final result of an input (a request matching both interfaces
// gives two). Ticks give no result. Configuration: cfg_valid/cfg_index/
// cfg_data write the interface count and addresses; cfg_ready is always high.
// Write configuration only while the block is idle.
// Flow: an input word is classified and queued at once (two-entry queue).
// Simple results pass from the queue through the engine's result register
// to the output register. A lookup or a reply update walks the cache at one
// entry per cycle, and a merge moves each later entry down one place with a
// read state and a write state (S_SH_RD, S_SH_WR); the cache memory has one
// read port and one write port.
// Reset clears the cache count, the seconds counter and the queue; entry
// contents need no clearing. A stalled m_tready holds the result register;
// the queue keeps accepting until full, then s_tready drops.
module arp_responder_with_lru_cache
	import arpc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 16,
	parameter int MAX_PORTS     = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // port, frame_bytes, ethertype, arp_op, sender_mac, sender_ip, target_ip
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [311:0] m_tdata,  // status, out_port, eth_dst, eth_src, out_op, out_sender_mac,
	                               // out_sender_ip, out_target_mac, out_target_ip, found_mac
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);

	cfg_t      cfg_q;
	cmd_t      cmd_in, cmd_out;
	logic      q_full, q_avail, q_pop;
	out_word_t m_word;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign m_tdata   = m_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{num_if: 2'd1, mac0: '0, ip0: '0, mac1: '0, ip1: '0};
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_IF:    cfg_q.num_if <= cfg_data[1:0];
				CFG_PORT0_MAC: cfg_q.mac0   <= cfg_data;
				CFG_PORT0_IP:  cfg_q.ip0    <= cfg_data[31:0];
				CFG_PORT1_MAC: cfg_q.mac1   <= cfg_data;
				CFG_PORT1_IP:  cfg_q.ip1    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	arpc_front #(.MAX_PORTS(MAX_PORTS)) u_front (
		.cfg  (cfg_q),
		.kind (s_tuser),
		.word (in_word_t'(s_tdata)),
		.cmd  (cmd_in)
	);

	arpc_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid),
		.push_cmd (cmd_in),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.pop_cmd  (cmd_out)
	);

	arpc_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_avail (q_avail),
		.cmd       (cmd_out),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_word    (m_word),
		.m_tlast   (m_tlast)
	);

endmodule

// File: hw/rtl/arpc_front.sv
// Front classifier: turns an input word into a cache-engine command.
// Depends on arpc_pkg; the checks that need no cache state are settled here.
module arpc_front
	import arpc_pkg::*;
#(
	parameter int MAX_PORTS = 2
) (
	input  cfg_t       cfg,
	input  logic [1:0] kind,
	input  in_word_t   word,
	output cmd_t       cmd
);

	logic [1:0]  nv;
	logic [31:0] pip;
	logic        m0, m1;

	always_comb begin
		nv  = (cfg.num_if > 2'(MAX_PORTS)) ? 2'(MAX_PORTS) : cfg.num_if;
		pip = word.port ? cfg.ip1 : cfg.ip0;
		m0  = (nv > 2'd0) && (word.target_ip == cfg.ip0);
		m1  = (nv > 2'd1) && (word.target_ip == cfg.ip1);

		cmd.kind   = CMD_SIMPLE;
		cmd.status = STAT_IGNORED;
		cmd.nrep   = 2'd1;
		cmd.port   = word.port;
		cmd.smac   = word.sender_mac;
		cmd.sip    = word.sender_ip;
		cmd.tip    = word.target_ip;

		if (kind == KIND_TICK) begin
			cmd.kind = CMD_TICK;
		end else if (kind != KIND_FRAME && kind != KIND_LOOKUP) begin
			cmd.status = STAT_IGNORED;
		end else if ({1'b0, word.port} >= nv) begin
			cmd.status = STAT_BADPORT;
		end else if (kind == KIND_LOOKUP) begin
			cmd.kind = CMD_LOOKUP;
		end else if (word.frame_bytes < MIN_FRAME) begin
			cmd.status = STAT_MALFORMED;
		end else if (word.ethertype != ETH_TYPE_ARP) begin
			cmd.status = STAT_BADTYPE;
		end else if (word.arp_op == ARP_OP_REPLY) begin
			if (word.sender_ip == pip) begin
				cmd.status = STAT_IGNORED;
			end else if (word.target_ip != pip) begin
				cmd.status = STAT_NOTME;
			end else begin
				cmd.kind = CMD_UPDATE;
			end
		end else if (word.arp_op == ARP_OP_REQ) begin
			if (!m0 && !m1) begin
				cmd.status = STAT_NOTME;
			end else begin
				cmd.kind = CMD_REQREPLY;
				cmd.nrep = {1'b0, m0} + {1'b0, m1};
			end
		end
	end

endmodule

// File: hw/rtl/arpc_cmd_fifo.sv
// Two-entry command queue between the classifier and the cache engine.
// Depends on arpc_pkg for the command type.
module arpc_cmd_fifo
	import arpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic avail,
	output cmd_t pop_cmd
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full    = (fill_q == 2'd2);
	assign avail   = (fill_q != 2'd0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && avail) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push && !full} - {1'b0, pop && avail};
		end
	end

endmodule

// File: hw/rtl/arpc_back.sv
// Cache engine: walks the IP-to-MAC cache for lookups and reply updates,
// keeps the seconds counter and drives the result register. Depends on arpc_pkg.
`include "arp_responder_with_lru_cache_macros.svh"
module arpc_back
	import arpc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      cmd_avail,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      m_tvalid,
	input  logic      m_tready,
	output out_word_t m_word,
	output logic      m_tlast
);

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CW = $clog2(CACHE_ENTRIES + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_SH_RD, S_SH_WR, S_EMIT} state_t;

	state_t      state_q;
	cmd_t        cur_q;
	logic [31:0] seconds_q;
	logic [CW-1:0] count_q, idx_q, j_q, jp1;
	logic [IW-1:0] cidx_q, mi_q, ii_q, best_q, target_q;
	logic        cmp_v_q, mi_v_q, ii_v_q, merge_q, append_q;
	logic [31:0] best_age_q, age;
	out_word_t   res_q, out_q, w_simple, w_reply, w_request, w_hit, w_cached;
	logic [1:0]  rep_q;
	logic        valid_q, last_q, slot_free;
	cmd_t        src;

	entry_t        mem [CACHE_ENTRIES];
	entry_t        rdata_q, wr_data;
	logic [IW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic          ip_eq, mac_eq, scan_done;
	logic [47:0]   pmac;
	logic [31:0]   pip;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		jp1       = j_q + CW'(1);
		rd_addr   = (state_q == S_SH_RD) ? jp1[IW-1:0] : idx_q[IW-1:0];
		wr_en     = (state_q == S_UPD) || (state_q == S_SH_WR);
		wr_addr   = (state_q == S_SH_WR) ? j_q[IW-1:0] : target_q;
		wr_data   = (state_q == S_SH_WR) ? rdata_q
			: '{ip: cur_q.sip, mac: cur_q.smac, port: cur_q.port, stamp: seconds_q};
		ip_eq     = rdata_q.ip == ((cur_q.kind == CMD_LOOKUP) ? cur_q.tip : cur_q.sip);
		mac_eq    = rdata_q.mac == cur_q.smac;
		age       = seconds_q - rdata_q.stamp;
		scan_done = !cmp_v_q && (idx_q >= count_q);
		slot_free = !valid_q || m_tready;
		cmd_pop   = (state_q == S_IDLE) && cmd_avail;

		src  = (state_q == S_IDLE) ? cmd : cur_q;
		pmac = src.port ? cfg.mac1 : cfg.mac0;
		pip  = src.port ? cfg.ip1 : cfg.ip0;

		w_simple        = '0;
		w_simple.status = src.status;

		w_hit           = '0;
		w_hit.status    = STAT_HIT;
		w_hit.found_mac = rdata_q.mac;

		w_cached        = '0;
		w_cached.status = STAT_CACHED;

		w_reply                = '0;
		w_reply.status         = STAT_REPLY;
		w_reply.out_port       = src.port;
		w_reply.eth_dst        = src.smac;
		w_reply.eth_src        = pmac;
		w_reply.out_op         = OUT_OP_REPLY;
		w_reply.out_sender_mac = pmac;
		w_reply.out_sender_ip  = pip;
		w_reply.out_target_mac = src.smac;
		w_reply.out_target_ip  = src.sip;

		w_request                = '0;
		w_request.status         = STAT_REQUEST;
		w_request.out_port       = src.port;
		w_request.eth_dst        = BCAST_MAC;
		w_request.eth_src        = pmac;
		w_request.out_op         = OUT_OP_REQ;
		w_request.out_sender_mac = pmac;
		w_request.out_sender_ip  = pip;
		w_request.out_target_ip  = src.tip;
	end

	assign m_tvalid = valid_q;
	assign m_word   = out_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			seconds_q <= '0;
			rep_q     <= '0;
			cmp_v_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_avail) begin
						cur_q   <= cmd;
						idx_q   <= '0;
						cmp_v_q <= 1'b0;
						mi_v_q  <= 1'b0;
						ii_v_q  <= 1'b0;
						case (cmd.kind)
							CMD_TICK: seconds_q <= seconds_q + 32'd1;
							CMD_SIMPLE: begin
								res_q   <= w_simple;
								rep_q   <= 2'd1;
								state_q <= S_EMIT;
							end
							CMD_REQREPLY: begin
								res_q   <= w_reply;
								rep_q   <= cmd.nrep;
								state_q <= S_EMIT;
							end
							default: state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN: begin
					// issue the next read while comparing the previous one
					if (idx_q < count_q) begin
						idx_q   <= idx_q + CW'(1);
						cidx_q  <= idx_q[IW-1:0];
						cmp_v_q <= 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
					end
					if (cmp_v_q) begin
						if (cur_q.kind == CMD_LOOKUP) begin
							if (ip_eq) begin
								res_q   <= w_hit;
								rep_q   <= 2'd1;
								state_q <= S_EMIT;
							end
						end else begin
							if (mac_eq) begin
								mi_q   <= cidx_q;
								mi_v_q <= 1'b1;
							end else if (ip_eq) begin
								ii_q   <= cidx_q;
								ii_v_q <= 1'b1;
							end
							if (cidx_q == '0 || age > best_age_q) begin
								best_age_q <= age;
								best_q     <= cidx_q;
							end
						end
					end else if (scan_done) begin
						if (cur_q.kind == CMD_LOOKUP) begin
							res_q   <= w_request;
							rep_q   <= 2'd1;
							state_q <= S_EMIT;
						end else begin
							merge_q  <= mi_v_q && ii_v_q;
							append_q <= !mi_v_q && !ii_v_q && (count_q < CW'(CACHE_ENTRIES));
							j_q      <= CW'(ii_q);
							if (mi_v_q) target_q <= mi_q;
							else if (ii_v_q) target_q <= ii_q;
							else if (count_q < CW'(CACHE_ENTRIES)) target_q <= count_q[IW-1:0];
							else target_q <= best_q;
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					res_q <= w_cached;
					rep_q <= 2'd1;
					if (merge_q) begin
						if (jp1 < count_q) begin
							state_q <= S_SH_RD;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= S_EMIT;
						end
					end else begin
						if (append_q) count_q <= count_q + CW'(1);
						state_q <= S_EMIT;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					// move the next entry down one place
					j_q <= jp1;
					if (jp1 + CW'(1) < count_q) begin
						state_q <= S_SH_RD;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_q   <= res_q;
						last_q  <= (rep_q == 2'd1);
						rep_q   <= rep_q - 2'd1;
						if (rep_q == 2'd1) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ARPC_ASSERT(a_count_bound, count_q <= CW'(CACHE_ENTRIES), "entry count above cache size")
	`ARPC_ASSERT(a_cmp_in_range, (state_q == S_SCAN && cmp_v_q) |-> (CW'(cidx_q) < count_q), "compare beyond filled entries")
	`ARPC_NEVER(a_emit_empty, state_q == S_EMIT && rep_q == 2'd0, "emit with no result left")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for arp_responder_with_lru_cache.
// Depends on arpc_pkg and the responder RTL; a scoreboard class predicts every
// result word from its own copy of the cache and the interface registers.
`timescale 1ns / 1ps

module tb;
	import arpc_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN      = 80;
	localparam int PHASE_ITEMS = 140;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		out_word_t w;
		bit        lst;
	} arp_result_t;

	class arp_scoreboard;
		logic [1:0]  num_if;
		logic [47:0] pmac [2];
		logic [31:0] pip [2];
		logic [31:0] e_ip [ENTRIES];
		logic [47:0] e_mac [ENTRIES];
		logic        e_port [ENTRIES];
		logic [31:0] e_stamp [ENTRIES];
		int          count;
		logic [31:0] seconds;
		arp_result_t pending_results [$];
		int          errors;
		int          n_in;

		function new();
			num_if = 2'd1;
			pmac[0] = '0; pmac[1] = '0;
			pip[0] = '0; pip[1] = '0;
			count = 0;
			seconds = '0;
			errors = 0;
			n_in = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [47:0] d);
			case (idx)
				CFG_NUM_IF:    num_if = d[1:0];
				CFG_PORT0_MAC: pmac[0] = d;
				CFG_PORT0_IP:  pip[0] = d[31:0];
				CFG_PORT1_MAC: pmac[1] = d;
				CFG_PORT1_IP:  pip[1] = d[31:0];
				default: ;
			endcase
		endfunction

		function void push(out_word_t w, bit lst);
			arp_result_t r;
			r.w = w;
			r.lst = lst;
			pending_results.push_back(r);
		endfunction

		function void push_status(status_t s);
			out_word_t w;
			w = '0;
			w.status = s;
			push(w, 1'b1);
		endfunction

		function void set_entry(int i, logic [31:0] ip, logic [47:0] mac, logic port);
			e_ip[i] = ip;
			e_mac[i] = mac;
			e_port[i] = port;
			e_stamp[i] = seconds;
		endfunction

		function int oldest();
			int best;
			logic [31:0] best_age, age;
			best = 0;
			best_age = seconds - e_stamp[0];
			for (int i = 1; i < count; i++) begin
				age = seconds - e_stamp[i];
				if (age > best_age) begin
					best_age = age;
					best = i;
				end
			end
			return best;
		endfunction

		function void update_cache(logic [31:0] ip, logic [47:0] mac, logic port);
			int mi, ii;
			mi = -1;
			ii = -1;
			for (int j = 0; j < count; j++) begin
				if (e_mac[j] == mac)
					mi = j;
				else if (e_ip[j] == ip)
					ii = j;
			end
			if (mi >= 0 && ii >= 0) begin
				// merge: the MAC entry wins, the IP entry is squeezed out
				set_entry(mi, ip, mac, port);
				for (int j = ii; j + 1 < count; j++) begin
					e_ip[j] = e_ip[j + 1];
					e_mac[j] = e_mac[j + 1];
					e_port[j] = e_port[j + 1];
					e_stamp[j] = e_stamp[j + 1];
				end
				count--;
			end else if (mi >= 0) begin
				set_entry(mi, ip, mac, port);
			end else if (ii >= 0) begin
				set_entry(ii, ip, mac, port);
			end else if (count < ENTRIES) begin
				set_entry(count, ip, mac, port);
				count++;
			end else begin
				set_entry(oldest(), ip, mac, port);
			end
		endfunction

		function void note_input(logic [1:0] kind, in_word_t w);
			int nv, n;
			out_word_t r;
			n_in++;
			nv = (num_if > 2) ? 2 : num_if;
			if (kind == KIND_TICK) begin
				seconds++;
				return;
			end
			if (kind == KIND_UNUSED) begin
				push_status(STAT_IGNORED);
				return;
			end
			if (w.port >= nv) begin
				push_status(STAT_BADPORT);
				return;
			end
			r = '0;
			if (kind == KIND_LOOKUP) begin
				for (int i = 0; i < count; i++) begin
					if (e_ip[i] == w.target_ip) begin
						r.status = STAT_HIT;
						r.found_mac = e_mac[i];
						push(r, 1'b1);
						return;
					end
				end
				r.status = STAT_REQUEST;
				r.out_port = w.port;
				r.eth_dst = BCAST_MAC;
				r.eth_src = pmac[w.port];
				r.out_op = OUT_OP_REQ;
				r.out_sender_mac = pmac[w.port];
				r.out_sender_ip = pip[w.port];
				r.out_target_ip = w.target_ip;
				push(r, 1'b1);
				return;
			end
			if (w.frame_bytes < MIN_FRAME) begin
				push_status(STAT_MALFORMED);
				return;
			end
			if (w.ethertype != ETH_TYPE_ARP) begin
				push_status(STAT_BADTYPE);
				return;
			end
			if (w.arp_op == ARP_OP_REPLY) begin
				if (w.sender_ip == pip[w.port])
					push_status(STAT_IGNORED);
				else if (w.target_ip != pip[w.port])
					push_status(STAT_NOTME);
				else begin
					update_cache(w.sender_ip, w.sender_mac, w.port);
					push_status(STAT_CACHED);
				end
				return;
			end
			if (w.arp_op == ARP_OP_REQ) begin
				n = 0;
				r.status = STAT_REPLY;
				r.out_port = w.port;
				r.eth_dst = w.sender_mac;
				r.eth_src = pmac[w.port];
				r.out_op = OUT_OP_REPLY;
				r.out_sender_mac = pmac[w.port];
				r.out_sender_ip = pip[w.port];
				r.out_target_mac = w.sender_mac;
				r.out_target_ip = w.sender_ip;
				for (int i = 0; i < nv; i++) begin
					if (w.target_ip == pip[i]) begin
						push(r, 1'b0);
						n++;
					end
				end
				if (n == 0)
					push_status(STAT_NOTME);
				else
					pending_results[$].lst = 1'b1;
				return;
			end
			push_status(STAT_IGNORED);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] exp);
			errors++;
			$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
		endtask

		task cmp(string what, logic [63:0] got, logic [63:0] exp);
			if (got !== exp)
				report(what, got, exp);
		endtask

		task check_result(out_word_t g, logic glast);
			arp_result_t e;
			if (pending_results.size() == 0) begin
				report("unexpected word", 64'(g.status), 64'hx);
				return;
			end
			e = pending_results.pop_front();
			cmp("status", 64'(g.status), 64'(e.w.status));
			cmp("out_port", 64'(g.out_port), 64'(e.w.out_port));
			cmp("eth_dst", 64'(g.eth_dst), 64'(e.w.eth_dst));
			cmp("eth_src", 64'(g.eth_src), 64'(e.w.eth_src));
			cmp("out_op", 64'(g.out_op), 64'(e.w.out_op));
			cmp("out_sender_mac", 64'(g.out_sender_mac), 64'(e.w.out_sender_mac));
			cmp("out_sender_ip", 64'(g.out_sender_ip), 64'(e.w.out_sender_ip));
			cmp("out_target_mac", 64'(g.out_target_mac), 64'(e.w.out_target_mac));
			cmp("out_target_ip", 64'(g.out_target_ip), 64'(e.w.out_target_ip));
			cmp("found_mac", 64'(g.found_mac), 64'(e.w.found_mac));
			cmp("last", 64'(glast), 64'(e.lst));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;  // port, frame_bytes, ethertype, arp_op, sender_mac, sender_ip, target_ip
	logic [1:0]   s_tuser = '0;  // kind
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [311:0] m_tdata;       // status, out_port, eth_dst, eth_src, out_op, out_sender_mac,
	                             // out_sender_ip, out_target_mac, out_target_ip, found_mac
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [47:0]  cfg_data = '0;

	arp_scoreboard sb = new();

	logic [31:0] ip_pool [24];
	logic [47:0] mac_pool [20];
	int          burst_left = 1;
	bit          gaps_on = 1'b1;
	int          idle_cycles = 0;

	arp_responder_with_lru_cache uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(out_word_t'(m_tdata), m_tlast);
	end

	// receiver: random stall patterns, plus one long hold-off
	initial begin
		int mode, cyc, hold;
		bit held;
		mode = 0;
		cyc = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 2);
			if (!held && sb.n_in >= 300) begin
				held = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task cfg_write(logic [2:0] idx, logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, d);
	endtask

	task send(logic [1:0] kind, in_word_t w);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, w);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 20);
			if (gaps_on) begin
				gap = $urandom_range(1, 12);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function in_word_t mk(logic port, logic [10:0] fb, logic [15:0] et, logic [15:0] op,
	                      logic [47:0] smac, logic [31:0] sip, logic [31:0] tip);
		in_word_t w;
		w = '0;
		w.port = port;
		w.frame_bytes = fb;
		w.ethertype = et;
		w.arp_op = op;
		w.sender_mac = smac;
		w.sender_ip = sip;
		w.target_ip = tip;
		return w;
	endfunction

	function in_word_t noise();
		return mk(1'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
		          48'({$urandom, $urandom}), $urandom, $urandom);
	endfunction

	// idle the block before touching registers
	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task configure(int p);
		logic [47:0] m0, m1;
		logic [31:0] i0, i1;
		logic [1:0]  n;
		m0 = 48'({$urandom, $urandom});
		m1 = 48'({$urandom, $urandom});
		i0 = $urandom;
		i1 = $urandom;
		case (p)
			0: n = 2'd1;
			1: begin
				n = 2'd2;
				m0 = '1; i0 = '1; m1 = '0; i1 = '0;
			end
			2: begin
				n = 2'd2;
				i1 = i0;  // both interfaces answer the same IP
			end
			3: n = 2'd0;
			default: n = 2'd3;
		endcase
		cfg_write(CFG_NUM_IF, 48'(n));
		cfg_write(CFG_PORT0_MAC, m0);
		cfg_write(CFG_PORT0_IP, 48'(i0));
		cfg_write(CFG_PORT1_MAC, m1);
		cfg_write(CFG_PORT1_IP, 48'(i1));
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
		ip_pool[0] = i0;
		ip_pool[1] = i1;
	endtask

	task directed();
		logic [31:0] me, ipa, ipb;
		logic [47:0] maca, macb;
		me = sb.pip[0];
		ipa = me ^ 32'h1;
		ipb = me ^ 32'h2;
		maca = 48'h0200_0000_00aa;
		macb = 48'h0200_0000_00bb;
		send(KIND_TICK, noise());
		send(KIND_UNUSED, noise());
		send(KIND_FRAME, mk(1'b1, 11'd60, ETH_TYPE_ARP, ARP_OP_REQ, maca, ipa, me));
		send(KIND_LOOKUP, mk(1'b1, 11'd60, ETH_TYPE_ARP, ARP_OP_REQ, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd0, ETH_TYPE_ARP, ARP_OP_REQ, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd13, ETH_TYPE_ARP, ARP_OP_REQ, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd14, 16'hffff, ARP_OP_REQ, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, 16'h0800, ARP_OP_REQ, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, 16'd0, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, 16'hffff, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, maca, me, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, maca, ipa, ipb));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, maca, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, macb, ipb, me));
		send(KIND_TICK, noise());
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, macb, ipb, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, macb, ipa, me));
		send(KIND_FRAME, mk(1'b0, 11'd60, ETH_TYPE_ARP, ARP_OP_REPLY, maca, ipb, me));
		send(KIND_LOOKUP, mk(1'b0, 11'd0, 16'd0, 16'd0, '0, '0, ipb));
		send(KIND_LOOKUP, mk(1'b0, 11'd0, 16'd0, 16'd0, '0, '0, ~ipb));
		send(KIND_FRAME, mk(1'b0, 11'd2047, ETH_TYPE_ARP, ARP_OP_REQ, '1, '1, me));
		send(KIND_FRAME, mk(1'b0, 11'd2047, ETH_TYPE_ARP, ARP_OP_REQ, '0, '0, ~me));
	endtask

	task random_item();
		int sel;
		logic [1:0] kind;
		in_word_t w;
		sel = $urandom_range(0, 99);
		w = noise();
		kind = KIND_FRAME;
		if (sel < 12) begin
			kind = KIND_TICK;
		end else if (sel < 15) begin
			kind = KIND_UNUSED;
		end else if (sel < 32) begin
			kind = KIND_LOOKUP;
			if ($urandom_range(0, 9) != 0)
				w.target_ip = ip_pool[$urandom_range(0, 23)];
		end else if (sel < 88) begin
			w.frame_bytes = 11'($urandom_range(14, 2047));
			w.ethertype = ETH_TYPE_ARP;
			w.sender_mac = mac_pool[$urandom_range(0, 19)];
			w.sender_ip = ip_pool[$urandom_range(0, 23)];
			if (sel < 50) begin
				w.arp_op = ARP_OP_REQ;
				w.target_ip = ip_pool[$urandom_range(0, 3)];
			end else begin
				w.arp_op = ARP_OP_REPLY;
				if ($urandom_range(0, 9) != 0)
					w.target_ip = sb.pip[w.port];
			end
		end else if (sel < 94) begin
			w.ethertype = ETH_TYPE_ARP;
		end
		send(kind, w);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 5; p++) begin
			configure(p);
			gaps_on = (p != 1);
			if (p == 0)
				directed();
			repeat (PHASE_ITEMS) random_item();
			drain();
		end
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_front.sv
hw/rtl/arpc_cmd_fifo.sv
hw/rtl/arpc_back.sv
hw/rtl/arp_responder_with_lru_cache.sv
tb/sv/tb.sv
